FILE: hdl/akvc_pkg.sv
package akvc_pkg;

   // field widths
   localparam int KEY_W   = 64;
   localparam int VAL_W   = 64;
   localparam int STAMP_W = 64;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;     // capture the incoming word
      logic scan_start;   // clear scan pointer, hit flag and result
      logic scan_step;    // issue one read, check the previous one
      logic ren_step;     // renumber one stamp, or close the pass
      logic write_entry;  // write key, value and stamp of a set
      logic out_load;     // move the result into the output register
   } akvc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_set;
      logic key_zero;
      logic bad_arg;
      logic ctr_max;
      logic scan_end;
      logic ren_done;
   } akvc_stat_type;

endpackage

FILE: hdl/akvc_ram.sv
module akvc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                  wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/akvc_dp.sv
module akvc_dp import akvc_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  akvc_cmd_type        cmd,
   output akvc_stat_type       stat,
   input  logic                req_func,
   input  logic [KEY_W-1:0]    req_key_id,
   input  logic [VAL_W-1:0]    req_value_id,
   output logic                rsp_status,
   output logic [VAL_W-1:0]    rsp_found_value
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // captured request word
   logic               func_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VAL_W-1:0]   val_ff;

   // table state
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STAMP_W-1:0] ctr_ff, ctr_in;

   // scan state
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [STAMP_W-1:0] min_ff, min_in;
   logic [IDX_W-1:0]   victim_ff, victim_in;
   logic [VAL_W-1:0]   res_value_ff, res_value_in;

   // output register payload
   logic               rsp_status_ff;
   logic [VAL_W-1:0]   rsp_value_ff;

   // memory ports
   logic [IDX_W-1:0]   raddr;
   logic [IDX_W-1:0]   kv_waddr;
   logic               st_we;
   logic [IDX_W-1:0]   st_waddr;
   logic [STAMP_W-1:0] st_wdata;
   logic [KEY_W-1:0]   rd_key;
   logic [VAL_W-1:0]   rd_value;
   logic [STAMP_W-1:0] rd_stamp;

   logic               issue;
   logic               key_match;
   logic               full;
   logic [STAMP_W-1:0] next_stamp;

   assign issue      = (scan_idx_ff < count_ff);
   assign key_match  = chk_vld_ff && (rd_key == key_ff);
   assign full       = (count_ff == CNT_W'(ENTRIES));
   assign next_stamp = ctr_ff + STAMP_W'(1);

   // slot chosen by a set: matching entry, next free slot, or oldest
   always_comb begin
      if (hit_ff) begin
         kv_waddr = hit_idx_ff;
      end else if (!full) begin
         kv_waddr = count_ff[IDX_W-1:0];
      end else begin
         kv_waddr = victim_ff;
      end
   end

   assign raddr    = scan_idx_ff[IDX_W-1:0];
   assign st_we    = cmd.write_entry || (cmd.ren_step && issue);
   assign st_waddr = cmd.write_entry ? kv_waddr : scan_idx_ff[IDX_W-1:0];
   assign st_wdata = cmd.write_entry ? next_stamp
                                     : (STAMP_W'(scan_idx_ff) + STAMP_W'(1));

   akvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (cmd.write_entry),
      .waddr (kv_waddr),
      .wdata (key_ff),
      .raddr (raddr),
      .rdata (rd_key)
   );

   akvc_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
      .clock (clock),
      .we    (cmd.write_entry),
      .waddr (kv_waddr),
      .wdata (val_ff),
      .raddr (raddr),
      .rdata (rd_value)
   );

   akvc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (raddr),
      .rdata (rd_stamp)
   );

   // scan, renumber and update next-state logic
   always_comb begin
      count_in     = count_ff;
      ctr_in       = ctr_ff;
      scan_idx_in  = scan_idx_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      min_in       = min_ff;
      victim_in    = victim_ff;
      res_value_in = res_value_ff;

      if (cmd.scan_start) begin
         scan_idx_in  = '0;
         chk_vld_in   = 1'b0;
         hit_in       = 1'b0;
         res_value_in = '0;
      end else if (cmd.scan_step) begin
         chk_vld_in = issue;
         chk_idx_in = scan_idx_ff[IDX_W-1:0];
         if (issue) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
         end
         if (chk_vld_ff) begin
            if (key_match) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
               if (!func_ff) begin
                  res_value_in = rd_value;
               end
            end
            // oldest stamp, lowest slot wins a tie
            if ((chk_idx_ff == '0) || (rd_stamp < min_ff)) begin
               min_in    = rd_stamp;
               victim_in = chk_idx_ff;
            end
         end
      end else if (cmd.ren_step) begin
         if (issue) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
         end else begin
            // pass closed: rewind the pointer for the key scan
            ctr_in      = STAMP_W'(count_ff);
            scan_idx_in = '0;
         end
      end

      if (cmd.write_entry) begin
         ctr_in = next_stamp;
         if (!hit_ff && !full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ctr_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         ctr_ff     <= ctr_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         key_ff  <= req_key_id;
         val_ff  <= req_value_id;
      end
      scan_idx_ff  <= scan_idx_in;
      chk_idx_ff   <= chk_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      min_ff       <= min_in;
      victim_ff    <= victim_in;
      res_value_ff <= res_value_in;
      if (cmd.out_load) begin
         rsp_status_ff <= stat.bad_arg;
         rsp_value_ff  <= res_value_ff;
      end
   end

   // status back to the controller
   assign stat.is_set   = func_ff;
   assign stat.key_zero = (key_ff == '0);
   assign stat.bad_arg  = func_ff && ((key_ff == '0) || (val_ff == '0));
   assign stat.ctr_max  = &ctr_ff;
   assign stat.scan_end = key_match || (!chk_vld_ff && !issue);
   assign stat.ren_done = !issue;

   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

FILE: hdl/akvc_ctrl.sv
module akvc_ctrl import akvc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  akvc_stat_type stat,
   output akvc_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_RENUM = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_DONE  = 6'b100000
   } akvc_state_type;

   akvc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.scan_start = 1'b1;
            if (!stat.is_set) begin
               state_in = stat.key_zero ? ST_DONE : ST_SCAN;
            end else if (stat.bad_arg) begin
               state_in = ST_DONE;
            end else if (stat.ctr_max) begin
               state_in = ST_RENUM;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_RENUM: begin
            cmd.ren_step = 1'b1;
            if (stat.ren_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_end) begin
               state_in = stat.is_set ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            cmd.write_entry = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/assoc_key_value_cache_oldest_evict.sv
// Accept to rsp_valid: a lookup of key zero or a rejected set skips the scan; other requests
//   scan the live entries in slot order, stopping early on a key hit; a set that wraps the
//   stamp counter first renumbers every live entry, and a set ends with a write of its entry.
// Throughput: one word in flight; the next is accepted in the cycle after the result is loaded,
//   and a result still held by the consumer delays that load.
// Reset (synchronous, active high) empties the table, zeroes the stamp counter and idles the controller.
module assoc_key_value_cache_oldest_evict import akvc_pkg::*; #(
   parameter int CACHE_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [KEY_W-1:0] req_key_id,
   input  logic [VAL_W-1:0] req_value_id,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_status,
   output logic [VAL_W-1:0] rsp_found_value
);

   akvc_cmd_type  cmd;
   akvc_stat_type stat;

   akvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   akvc_dp #(.ENTRIES(CACHE_ENTRIES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_key_id      (req_key_id),
      .req_value_id    (req_value_id),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule

FILE: tb/assoc_key_value_cache_oldest_evict_tb.sv
module assoc_key_value_cache_oldest_evict_tb;
   import akvc_pkg::*;

   // request operations and response status codes
   localparam bit FN_LOOKUP  = 1'b0;
   localparam bit FN_SET     = 1'b1;
   localparam bit ST_OK      = 1'b0;
   localparam bit ST_BAD_ARG = 1'b1;

   localparam int NUM_SLOTS  = 16;
   localparam int IDLE_LIMIT = 2000;

   typedef struct {
      bit             func;
      bit [KEY_W-1:0] key;
      bit [VAL_W-1:0] value;
      int             idle_after;
   } cache_req_type;

   typedef struct {
      bit             status;
      bit [VAL_W-1:0] found;
   } cache_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_func = 1'b0;
   logic [KEY_W-1:0] req_key_id = '0;
   logic [VAL_W-1:0] req_value_id = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_status;
   logic [VAL_W-1:0] rsp_found_value;

   cache_req_type pending_req[$];
   cache_rsp_type expected_rsp[$];
   int         words_accepted = 0;
   int         total_words = 0;
   int         fail_count = 0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         rsp_seen = 0;
   int         idle_cycles = 0;
   bit         quiet_gaps = 1'b0;

   // shadow copy of the table
   bit [KEY_W-1:0]   shadow_keys[NUM_SLOTS];
   bit [VAL_W-1:0]   shadow_values[NUM_SLOTS];
   bit [STAMP_W-1:0] shadow_stamps[NUM_SLOTS];
   int               shadow_count = 0;
   bit [STAMP_W-1:0] shadow_seq = '0;

   assoc_key_value_cache_oldest_evict #(.CACHE_ENTRIES(NUM_SLOTS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_key_id      (req_key_id),
      .req_value_id    (req_value_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // applies one request to the shadow table and returns the response it should give
   function automatic cache_rsp_type apply_cache_request(input bit fn, input bit [KEY_W-1:0] key,
                                                        input bit [VAL_W-1:0] val);
      cache_rsp_type rsp;
      int         slot;
      int         oldest;
      rsp.status = ST_OK;
      rsp.found  = '0;
      slot = -1;
      for (int i = 0; i < shadow_count; i++)
         if (slot < 0 && shadow_keys[i] == key)
            slot = i;
      if (fn == FN_LOOKUP) begin
         if (key != '0 && slot >= 0)
            rsp.found = shadow_values[slot];
         return rsp;
      end
      if (key == '0 || val == '0) begin
         rsp.status = ST_BAD_ARG;
         return rsp;
      end
      // sequence wrap: restamp live entries in slot order
      if (shadow_seq == '1) begin
         for (int i = 0; i < shadow_count; i++)
            shadow_stamps[i] = STAMP_W'(i + 1);
         shadow_seq = STAMP_W'(shadow_count);
      end
      shadow_seq++;
      if (slot < 0 && shadow_count < NUM_SLOTS) begin
         slot = shadow_count;
         shadow_count++;
      end else if (slot < 0) begin
         // evict least recently written, lowest slot on a tie
         oldest = 0;
         for (int i = 1; i < NUM_SLOTS; i++)
            if (shadow_stamps[i] < shadow_stamps[oldest])
               oldest = i;
         slot = oldest;
      end
      shadow_keys[slot]   = key;
      shadow_values[slot] = val;
      shadow_stamps[slot] = shadow_seq;
      return rsp;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit [63:0] nonzero64();
      bit [63:0] r;
      do
         r = rand64();
      while (r == '0);
      return r;
   endfunction

   task automatic push_req(input bit fn, input bit [KEY_W-1:0] key, input bit [VAL_W-1:0] val);
      cache_req_type item;
      item.func       = fn;
      item.key        = key;
      item.value      = val;
      item.idle_after = quiet_gaps ? 0 : pick_gap();
      pending_req.push_back(item);
   endtask

   // request driver
   always @(posedge clock) begin
      cache_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(apply_cache_request(req_func, req_key_id, req_value_id));
            words_accepted++;
         end
         if (req_valid && !req_ready) begin
            // hold the word until taken
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_req.size() > 0) begin
            nxt = pending_req.pop_front();
            req_valid    <= 1'b1;
            req_func     <= nxt.func;
            req_key_id   <= nxt.key;
            req_value_id <= nxt.value;
            gap_left     <= nxt.idle_after;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      cache_rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               $error("unexpected word: status %0d found_value %h", rsp_status, rsp_found_value);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_found_value !== want.found) begin
                  $error("found_value: expected %h, actual %h", want.found, rsp_found_value);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ((rsp_seen / 200) % 4 != 1 && $urandom_range(0, 5) == 0) begin
            // every fourth stretch of 200 words runs without stalls
            rsp_ready  <= 1'b0;
            stall_left <= pick_gap();
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int             sel;
      int             pool_size;
      bit [KEY_W-1:0] key;
      bit [KEY_W-1:0] key_pool[$];

      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_keys[i]   = '0;
         shadow_values[i] = '0;
         shadow_stamps[i] = '0;
      end

      // directed: zero key, miss, rejected sets, extremes, update, fill, eviction
      push_req(FN_LOOKUP, '0, '1);
      push_req(FN_LOOKUP, 64'd1, '0);
      push_req(FN_SET, '0, 64'd5);
      push_req(FN_SET, 64'd5, '0);
      push_req(FN_SET, '0, '0);
      push_req(FN_SET, '1, '1);
      push_req(FN_LOOKUP, '1, '0);
      push_req(FN_SET, 64'd1, 64'd1);
      push_req(FN_SET, '1, 64'h8000_0000_0000_0001);
      push_req(FN_LOOKUP, '1, '0);
      push_req(FN_LOOKUP, '0, '0);
      for (int k = 2; k <= NUM_SLOTS; k++)
         push_req(FN_SET, 64'(k), 64'(k) << 48);
      // table full: key 16 pushed out key 1, key 100 pushes out the all-ones key
      push_req(FN_SET, 64'd100, 64'h7fff_ffff_ffff_ffff);
      push_req(FN_LOOKUP, 64'd1, '0);
      push_req(FN_LOOKUP, 64'd100, '0);

      // random: per phase a key pool below, near and well above the table size
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: pool_size = 6;
            1: pool_size = 20;
            2: pool_size = 17;
            default: pool_size = 40;
         endcase
         quiet_gaps = (ph == 2);
         key_pool.delete();
         for (int k = 0; k < pool_size; k++)
            key_pool.push_back(nonzero64());
         repeat (455) begin
            sel = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, pool_size - 1)];
            if (sel < 45)
               push_req(FN_SET, key, nonzero64());
            else if (sel < 85)
               push_req(FN_LOOKUP, key, rand64());
            else if (sel < 90)
               push_req(FN_LOOKUP, rand64(), rand64());
            else if (sel < 92)
               push_req(FN_LOOKUP, '0, rand64());
            else if (sel < 94)
               push_req(FN_SET, '0, rand64());
            else if (sel < 96)
               push_req(FN_SET, key, '0);
            else
               push_req(FN_SET, nonzero64(), nonzero64());
         end
      end
      total_words = pending_req.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain, then a quiet tail to catch stray words
      while (words_accepted != total_words || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
